/* sv/psor_pkg.sv */
`timescale 1ns / 1ps
// shared constants and codes for the red-black sor poisson block
// no dependencies
package psor_pkg;

	localparam int PSOR_MAX_SIDE = 64;
	localparam int DATA_W        = 32;
	localparam int GAMMA_W       = 18;
	localparam int SWEEP_W       = 16;
	localparam int SIZE_W        = 7;
	localparam int DONE_W        = 17;
	localparam int RELAX_SHIFT   = 18;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_RUN    = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] REG_RELAX  = 2'd0;
	localparam logic [1:0] REG_SWEEPS = 2'd1;
	localparam logic [1:0] REG_SIZE   = 2'd2;

	localparam logic [GAMMA_W-1:0] RELAX_RESET  = 18'd65536;
	localparam logic [SWEEP_W-1:0] SWEEPS_RESET = 16'd1000;
	localparam logic [SIZE_W-1:0]  SIZE_RESET   = 7'd64;

endpackage

/* sv/psor_grid_mem.sv */
`timescale 1ns / 1ps
// grid store: one write port, one read port, registered read data
// depends on nothing
module psor_grid_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/psor_update.sv */
`timescale 1ns / 1ps
// cell update: laplacian times gamma, floor shift, saturating add
// depends on psor_pkg
module psor_update
	import psor_pkg::*;
(
	input  logic                      clk,
	input  logic signed [DATA_W+1:0]  nb_sum,
	input  logic signed [DATA_W-1:0]  center,
	input  logic        [GAMMA_W-1:0] gamma,
	output logic signed [DATA_W-1:0]  result
);

	localparam int LAP_W  = DATA_W + 3;
	localparam int PROD_W = LAP_W + GAMMA_W + 1;
	localparam int DEL_W  = PROD_W - RELAX_SHIFT;

	logic signed [LAP_W-1:0]  lap;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [DATA_W-1:0] center_s1;
	logic signed [DEL_W-1:0]  delta;
	logic signed [DEL_W:0]    total;
	logic signed [DATA_W-1:0] sat;

	assign lap = LAP_W'(nb_sum) - (LAP_W'(center) <<< 2);

	// arithmetic shift gives floor for negative products too
	assign delta = DEL_W'(prod_s1 >>> RELAX_SHIFT);
	assign total = (DEL_W+1)'(center_s1) + (DEL_W+1)'(delta);

	always_comb begin
		if (total > (DEL_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (total < -(DEL_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}})) - 1) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = DATA_W'(total);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1   <= PROD_W'(lap) * PROD_W'(signed'({1'b0, gamma}));
		center_s1 <= center;
		result    <= sat;
	end

endmodule

/* sv/poisson_red_black_sor.sv */
`timescale 1ns / 1ps
// top level: command sequencer, config registers and output register
// depends on psor_pkg, psor_grid_mem, psor_update
//
// channel | direction | handshake          | words
// in      | in        | in_valid/in_stall  | operation, row, col, cell_value
// out     | out       | out_valid/out_stall| read_value, sweeps_done
// cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// write: taken straight into the grid; read: through the registered memory port, then the output register
// run: each interior cell of the current colour takes a scan step, 5 reads
// on the single read port, multiply, saturate and write back; a cell of the
// wrong colour takes only a scan step; two colour passes make a sweep
// reset clears control and loads config with its defaults; the grid holds nothing until written
// the block takes no word while a read or a run is going or a result waits stalled
module poisson_red_black_sor
	import psor_pkg::*;
#(
	parameter int MAX_SIDE = PSOR_MAX_SIDE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [5:0]                row,
	input  logic [5:0]                col,
	input  logic signed [DATA_W-1:0]  cell_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  read_value,
	output logic [DONE_W-1:0]         sweeps_done,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [GAMMA_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_SIDE);
	localparam int SW    = ($clog2(MAX_SIDE + 1) > SIZE_W) ? $clog2(MAX_SIDE + 1) : SIZE_W;

	localparam logic [2:0] TAP_N = 3'd0;
	localparam logic [2:0] TAP_S = 3'd1;
	localparam logic [2:0] TAP_W = 3'd2;
	localparam logic [2:0] TAP_E = 3'd3;
	localparam logic [2:0] TAP_C = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RDOUT, ST_FIND, ST_RD, ST_LAST, ST_MUL, ST_ADD, ST_WR
	} state_t;

	state_t                    state_q;
	logic [GAMMA_W-1:0]        relax_q;
	logic [SWEEP_W-1:0]        max_sweeps_q;
	logic [SIZE_W-1:0]         size_q;
	logic [SW-1:0]             side_q;
	logic [CW-1:0]             r_q, c_q;
	logic                      parity_q;
	logic [DONE_W-1:0]         sweep_q, total_q;
	logic [2:0]                tap_q;
	logic signed [DATA_W+1:0]  sum_q;
	logic signed [DATA_W-1:0]  center_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  read_value_q;
	logic [DONE_W-1:0]         sweeps_done_q;

	logic                      in_acc, in_range;
	logic [AW-1:0]             in_addr, rd_addr, wr_addr, cell_addr;
	logic [DATA_W-1:0]         wr_data, rd_data;
	logic                      wr_en;
	logic signed [DATA_W-1:0]  upd_result;
	logic [SW-1:0]             run_side;
	logic [DONE_W-1:0]         run_total;
	logic                      last_col, last_row, colour_ok;
	logic [CW-1:0]             tr, tc;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign in_range = (int'(row) < MAX_SIDE) && (int'(col) < MAX_SIDE);
	assign in_addr  = AW'(int'(row) * MAX_SIDE + int'(col));

	assign run_side  = (int'(size_q) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(size_q);
	assign run_total = (DONE_W'(max_sweeps_q) + DONE_W'(1)) & ~DONE_W'(1);

	assign last_col  = ((SW+1)'(c_q) + (SW+1)'(2)) == (SW+1)'(side_q);
	assign last_row  = ((SW+1)'(r_q) + (SW+1)'(2)) == (SW+1)'(side_q);
	assign colour_ok = (r_q[0] ^ c_q[0]) == parity_q;

	// neighbour or centre address for the current read tap
	always_comb begin
		tr = r_q;
		tc = c_q;
		case (tap_q)
			TAP_N:   tr = r_q - CW'(1);
			TAP_S:   tr = r_q + CW'(1);
			TAP_W:   tc = c_q - CW'(1);
			TAP_E:   tc = c_q + CW'(1);
			default: ;
		endcase
	end

	assign cell_addr = AW'(int'(r_q) * MAX_SIDE + int'(c_q));
	assign rd_addr   = (state_q == ST_IDLE) ? in_addr : AW'(int'(tr) * MAX_SIDE + int'(tc));
	assign wr_en     = (state_q == ST_WR) ||
	                   (in_acc && operation == OP_WRITE && in_range);
	assign wr_addr   = (state_q == ST_WR) ? cell_addr : in_addr;
	assign wr_data   = (state_q == ST_WR) ? upd_result : cell_value;

	psor_grid_mem #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (DATA_W)
	) u_mem (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	psor_update u_upd (
		.clk   (clk),
		.nb_sum(sum_q),
		.center(center_q),
		.gamma (relax_q),
		.result(upd_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q      <= RELAX_RESET;
			max_sweeps_q <= SWEEPS_RESET;
			size_q       <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RELAX:  relax_q      <= cfg_data;
				REG_SWEEPS: max_sweeps_q <= cfg_data[SWEEP_W-1:0];
				REG_SIZE:   size_q       <= cfg_data[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			r_q           <= '0;
			c_q           <= '0;
			parity_q      <= 1'b0;
			sweep_q       <= '0;
			total_q       <= '0;
			tap_q         <= '0;
			side_q        <= '0;
			sum_q         <= '0;
			center_q      <= '0;
			read_value_q  <= '0;
			sweeps_done_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						read_value_q  <= '0;
						sweeps_done_q <= '0;
						case (operation)
							OP_READ: state_q <= ST_RDOUT;
							OP_RUN: begin
								side_q   <= run_side;
								total_q  <= run_total;
								sweep_q  <= '0;
								r_q      <= CW'(1);
								c_q      <= CW'(1);
								parity_q <= 1'b0;
								if (run_total == '0 || run_side < SW'(3)) begin
									sweeps_done_q <= run_total;
									out_valid_q   <= 1'b1;
								end else begin
									state_q <= ST_FIND;
								end
							end
							default: out_valid_q <= 1'b1;
						endcase
						if (operation == OP_READ && !in_range) begin
							state_q     <= ST_IDLE;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_RDOUT: begin
					read_value_q <= rd_data;
					out_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_FIND, ST_WR: begin
					if (state_q == ST_FIND && colour_ok) begin
						tap_q   <= TAP_N;
						sum_q   <= '0;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_FIND;
						if (!last_col) begin
							c_q <= c_q + CW'(1);
						end else begin
							c_q <= CW'(1);
							if (!last_row) begin
								r_q <= r_q + CW'(1);
							end else begin
								// end of one colour pass
								r_q      <= CW'(1);
								parity_q <= !parity_q;
								if (parity_q) begin
									sweep_q <= sweep_q + DONE_W'(1);
									if (sweep_q + DONE_W'(1) == total_q) begin
										sweeps_done_q <= total_q;
										out_valid_q   <= 1'b1;
										state_q       <= ST_IDLE;
									end
								end
							end
						end
					end
				end
				ST_RD: begin
					// data of the previous tap arrives now
					if (tap_q != TAP_N) begin
						sum_q <= sum_q + (DATA_W+2)'(signed'(rd_data));
					end
					if (tap_q == TAP_C) begin
						state_q <= ST_LAST;
					end else begin
						tap_q <= tap_q + 3'd1;
					end
				end
				ST_LAST: begin
					center_q <= rd_data;
					state_q  <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_WR;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign sweeps_done = sweeps_done_q;

endmodule

/* dv/tb_poisson_red_black_sor.sv */
`timescale 1ns / 1ps
// self-checking testbench for the red-black sor poisson block
// depends on psor_pkg and poisson_red_black_sor; predicts each result in-line
module tb_poisson_red_black_sor;
	import psor_pkg::*;

	localparam int SIDE      = PSOR_MAX_SIDE;
	localparam int LIMIT     = 6000000;
	localparam int TAIL_WAIT = 40;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [DONE_W-1:0]        sweeps;
	} result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               operation = OP_WRITE;
	logic [5:0]               row = '0;
	logic [5:0]               col = '0;
	logic signed [DATA_W-1:0] cell_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic [DONE_W-1:0]        sweeps_done;
	logic                     cfg_we = 1'b0;
	logic [1:0]               cfg_index = REG_RELAX;
	logic [GAMMA_W-1:0]       cfg_data = '0;

	// predictor state
	logic signed [DATA_W-1:0] grid_model [SIDE*SIDE];
	bit                       grid_written [SIDE*SIDE];
	int                       written_cells [$];
	logic [GAMMA_W-1:0]       gamma_now = RELAX_RESET;
	logic [SWEEP_W-1:0]       sweep_limit = SWEEPS_RESET;
	logic [SIZE_W-1:0]        side_now = SIZE_RESET;

	logic [GAMMA_W-1:0] gamma_list [5] = '{18'd0, 18'd65536, 18'd131072, 18'd98304, 18'd200000};

	result_t expected_results [$];
	int      mismatch_count = 0;
	int      words_sent = 0;
	int      results_seen = 0;
	int      runs_sent = 0;
	int      cycle_count = 0;
	int      hold_cycles = 0;
	bit      quiet = 1'b0;

	poisson_red_black_sor DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .row(row), .col(col), .cell_value(cell_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .sweeps_done(sweeps_done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatch_count++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic logic signed [DATA_W-1:0] relax_cell(input int k);
		logic signed [63:0] lap;
		logic signed [63:0] delta;
		logic signed [63:0] sum;
		lap = 64'(grid_model[k-SIDE]) + 64'(grid_model[k+SIDE]) + 64'(grid_model[k-1])
			+ 64'(grid_model[k+1]) - 4 * 64'(grid_model[k]);
		// arithmetic shift of a signed product floors
		delta = (lap * $signed({46'd0, gamma_now})) >>> RELAX_SHIFT;
		sum = 64'(grid_model[k]) + delta;
		if (sum > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (sum < -64'sh80000000) return 32'sh80000000;
		return sum[31:0];
	endfunction

	function automatic result_t predict_word(input logic [1:0] op, input int r, input int c,
			input logic signed [DATA_W-1:0] v);
		result_t res;
		int side;
		int sweeps;
		res = '0;
		case (op)
			OP_WRITE: begin
				grid_model[r*SIDE+c] = v;
			end
			OP_RUN: begin
				side = (side_now > SIDE) ? SIDE : side_now;
				sweeps = (int'(sweep_limit) + 1) & ~1;
				for (int s = 0; s < sweeps && side >= 3; s++)
					for (int parity = 0; parity < 2; parity++)
						for (int i = 1; i + 1 < side; i++)
							for (int j = 1; j + 1 < side; j++)
								if (((i + j) & 1) == parity)
									grid_model[i*SIDE+j] = relax_cell(i*SIDE+j);
				res.sweeps = sweeps[DONE_W-1:0];
			end
			OP_READ: begin
				res.value = grid_model[r*SIDE+c];
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_word(input logic [1:0] op, input int r, input int c,
			input logic signed [DATA_W-1:0] v);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		row <= r[5:0];
		col <= c[5:0];
		cell_value <= v;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		expected_results.push_back(predict_word(op, r, c, v));
		if (op == OP_WRITE && !grid_written[r*SIDE+c]) begin
			grid_written[r*SIDE+c] = 1'b1;
			written_cells.push_back(r*SIDE+c);
		end
		if (op == OP_RUN) runs_sent++;
		words_sent++;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [GAMMA_W-1:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RELAX:  gamma_now = data;
			REG_SWEEPS: sweep_limit = data[SWEEP_W-1:0];
			REG_SIZE:   side_now = data[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [DATA_W-1:0] rand_cell();
		if ($urandom_range(0, 2) == 0) return $urandom;
		return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
	endfunction

	task automatic fill_grid(input int side);
		for (int i = 0; i < side; i++)
			for (int j = 0; j < side; j++)
				send_word(OP_WRITE, i, j, rand_cell());
	endtask

	task automatic read_some(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = written_cells[$urandom_range(0, written_cells.size() - 1)];
			send_word(OP_READ, k / SIDE, k % SIDE, rand_cell());
		end
	endtask

	task automatic test_directed_extremes();
		send_word(OP_WRITE, 63, 63, 32'sh80000000);
		send_word(OP_WRITE, 0, 0, 32'sh7FFFFFFF);
		send_word(OP_WRITE, 63, 0, 32'sh00000000);
		send_word(OP_WRITE, 0, 63, -32'sh1);
		send_word(OP_READ, 63, 63, '0);
		send_word(OP_READ, 0, 0, '0);
		send_word(OP_READ, 63, 0, '0);
		send_word(OP_READ, 0, 63, '0);
		send_word(OP_UNUSED, 21, 42, 32'sh55555555);
		// side below three has no interior: only the sweep count comes back
		write_reg(REG_SIZE, 18'd2);
		write_reg(REG_SWEEPS, 18'd65535);
		send_word(OP_RUN, 0, 0, '0);
		write_reg(REG_SIZE, 18'd0);
		write_reg(REG_SWEEPS, 18'd0);
		send_word(OP_RUN, 63, 63, '0);
		// three by three with saturating neighbours and the largest gamma
		write_reg(REG_SIZE, 18'd3);
		write_reg(REG_SWEEPS, 18'd1);
		write_reg(REG_RELAX, 18'h3FFFF);
		send_word(OP_WRITE, 0, 1, 32'sh7FFFFFFF);
		send_word(OP_WRITE, 1, 0, 32'sh7FFFFFFF);
		send_word(OP_WRITE, 1, 1, 32'sh80000000);
		send_word(OP_WRITE, 1, 2, 32'sh7FFFFFFF);
		send_word(OP_WRITE, 2, 1, 32'sh7FFFFFFF);
		send_word(OP_WRITE, 0, 2, '0);
		send_word(OP_WRITE, 2, 0, '0);
		send_word(OP_WRITE, 2, 2, '0);
		send_word(OP_RUN, 0, 0, '0);
		send_word(OP_READ, 1, 1, '0);
	endtask

	task automatic test_gamma_extremes();
		write_reg(REG_SIZE, 18'd5);
		write_reg(REG_SWEEPS, 18'd2);
		fill_grid(5);
		foreach (gamma_list[i]) begin
			write_reg(REG_RELAX, gamma_list[i]);
			send_word(OP_RUN, 0, 0, '0);
			read_some(4);
		end
	endtask

	task automatic test_wide_side();
		// a wider grid, then a smaller side over the same contents
		write_reg(REG_SIZE, 18'd24);
		write_reg(REG_SWEEPS, 18'd1);
		write_reg(REG_RELAX, 18'd80000);
		fill_grid(24);
		send_word(OP_RUN, 0, 0, '0);
		read_some(20);
		write_reg(REG_SIZE, 18'd20);
		send_word(OP_RUN, 0, 0, '0);
		read_some(10);
	endtask

	task automatic test_random_phases(input int phases);
		int side;
		int n;
		for (int p = 0; p < phases; p++) begin
			side = $urandom_range(3, 9);
			write_reg(REG_SIZE, 18'(side));
			write_reg(REG_SWEEPS, 18'($urandom_range(0, 5)));
			write_reg(REG_RELAX, 18'($urandom_range(0, 131072)));
			fill_grid(side);
			n = $urandom_range(10, 30);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0:       send_word(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), '0);
					1, 2, 3: send_word(OP_WRITE, $urandom_range(0, side - 1),
						$urandom_range(0, side - 1), rand_cell());
					4:       send_word(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
						rand_cell());
					5:       send_word(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom);
					default: read_some(1);
				endcase
			end
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_SIZE, 18'd4);
		write_reg(REG_SWEEPS, 18'd3);
		hold_cycles = 300;
		for (int i = 0; i < 30; i++) begin
			if (i == 10) send_word(OP_RUN, 0, 0, '0);
			else if (i % 3 == 0) read_some(1);
			else send_word(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), rand_cell());
		end
		drain();
	endtask

	// output side stall bursts and the long hold
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker: sampled mid-cycle, away from the driving edge
	initial begin
		result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report("unexpected word", {read_value, 15'd0, sweeps_done}, '0);
				end else begin
					want = expected_results.pop_front();
					if (read_value !== want.value)
						report("read_value", 64'(read_value), 64'(want.value));
					if (sweeps_done !== want.sweeps)
						report("sweeps_done", 64'(sweeps_done), 64'(want.sweeps));
				end
			end
		end
	end

	initial begin
		foreach (grid_model[i]) begin
			grid_model[i] = '0;
			grid_written[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_gamma_extremes();
		test_backpressure();
		test_random_phases(18);
		test_wide_side();
		quiet = 1'b1;
		test_random_phases(5);
		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (expected_results.size() != 0)
			report("missing words", 64'(expected_results.size()), '0);
		$display("covered %0d words sent, %0d runs, %0d results checked",
			words_sent, runs_sent, results_seen);
		$display("sides 0 to 24, gamma 0 to max, sweep limits 0 to 65535, long output hold");
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
